// ===== src/hsa_pkg.sv =====
// Shared types, constants and the arctangent table of the slope and aspect unit.
package hsa_pkg;

    localparam int ELEV_WIDTH      = 24;
    localparam int ANGLE_FRAC_BITS = 14;
    localparam int SPACING_W       = 16;
    localparam int CFG_IDX_W       = 8;
    localparam int ITERS           = 30;
    localparam int ITER_W          = 5;
    localparam int DIFF_W          = ELEV_WIDTH + 3;
    localparam int NW              = 58;
    localparam int CW              = 64;
    localparam int ZW              = 36;
    localparam int SLOPE_W         = 15;
    localparam int ASPECT_W        = 17;
    localparam int NORM_STAGES     = 6;
    localparam int IN_DATA_W       = 9 * ELEV_WIDTH;
    localparam int OUT_DATA_W      = 56;
    localparam logic signed [ZW-1:0] PI_Q30 = 36'sd3373259426;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EW_SPACING = 8'd0,
        CFG_NS_SPACING = 8'd1
    } cfg_idx_t;

    // Sideband that rides along the rotation stages
    typedef struct packed {
        logic                         win_ok;
        logic                         flat;
        logic signed [ELEV_WIDTH-1:0] centre;
        logic signed [ZW-1:0]         ang;
    } side_t;

    // One normalization stage
    typedef struct packed {
        logic                         vld;
        logic                         a_pos;
        logic                         b_neg;
        logic                         flat;
        logic                         win_ok;
        logic signed [ELEV_WIDTH-1:0] centre;
        logic [NW-1:0]                mx;
        logic [NW-1:0]                my;
        logic [NW-1:0]                md;
        logic [NW-1:0]                m;
    } norm_t;

    // atan(2^-i) in units of 2^-30 rad, truncated
    function automatic logic [31:0] atan_q30(input logic [ITER_W-1:0] i);
        logic [31:0] r;
        unique case (i)
            5'd0:  r = 32'h3243F6A8;
            5'd1:  r = 32'h1DAC6705;
            5'd2:  r = 32'h0FADBAFC;
            5'd3:  r = 32'h07F56EA6;
            5'd4:  r = 32'h03FEAB76;
            5'd5:  r = 32'h01FFD55B;
            5'd6:  r = 32'h00FFFAAA;
            5'd7:  r = 32'h007FFF55;
            5'd8:  r = 32'h003FFFEA;
            5'd9:  r = 32'h001FFFFD;
            5'd10: r = 32'h000FFFFF;
            5'd11: r = 32'h0007FFFF;
            5'd12: r = 32'h0003FFFF;
            5'd13: r = 32'h0001FFFF;
            5'd14: r = 32'h0000FFFF;
            5'd15: r = 32'h00007FFF;
            5'd16: r = 32'h00003FFF;
            5'd17: r = 32'h00001FFF;
            5'd18: r = 32'h00000FFF;
            5'd19: r = 32'h000007FF;
            5'd20: r = 32'h000003FF;
            5'd21: r = 32'h000001FF;
            5'd22: r = 32'h000000FF;
            5'd23: r = 32'h0000007F;
            5'd24: r = 32'h0000003F;
            5'd25: r = 32'h0000001F;
            5'd26: r = 32'h0000000F;
            5'd27: r = 32'h00000007;
            5'd28: r = 32'h00000003;
            5'd29: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

// ===== src/hsa_front.sv =====
// Front end: Horn differences, spacing products, normalization and rotation setup.
module hsa_front
    import hsa_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        vld_i,
    input  logic [IN_DATA_W-1:0]        elev_i,
    input  logic                        win_ok_i,
    input  logic [SPACING_W-1:0]        ew_i,
    input  logic [SPACING_W-1:0]        ns_i,
    output logic                        vld_o,
    output logic signed [CW-1:0]        x_o,
    output logic signed [CW-1:0]        y_o,
    output logic signed [CW-1:0]        d_o,
    output side_t                       side_o
);

    logic signed [DIFF_W-1:0] z [0:8];
    logic signed [DIFF_W-1:0] a_next, b_next;

    // Stage 1 registers
    logic                         v1_reg, ok1_reg;
    logic signed [DIFF_W-1:0]     a_reg, b_reg;
    logic signed [ELEV_WIDTH-1:0] c1_reg;
    logic [SPACING_W-1:0]         ew_reg, ns_reg;

    // Stage 2 registers
    logic                         v2_reg, ok2_reg, apos2_reg, bneg2_reg, flat2_reg;
    logic signed [ELEV_WIDTH-1:0] c2_reg;
    logic [NW-1:0]                mx_reg, my_reg, md_reg;

    logic [DIFF_W-1:0]            abs_a, abs_b;
    logic [NW-1:0]                max_next;

    norm_t nrm_reg [0:NORM_STAGES];

    // Unpack and sign-extend the nine elevations
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            z[k] = DIFF_W'(signed'(elev_i[k*ELEV_WIDTH +: ELEV_WIDTH]));
        end
        a_next = (z[2] + (z[5] <<< 1) + z[8]) - (z[0] + (z[3] <<< 1) + z[6]);
        b_next = (z[6] + (z[7] <<< 1) + z[8]) - (z[0] + (z[1] <<< 1) + z[2]);
    end

    // Stage 1: weighted differences, spacing with zero read as one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= vld_i;
        end
        if (en) begin
            ok1_reg <= win_ok_i;
            a_reg   <= a_next;
            b_reg   <= b_next;
            c1_reg  <= elev_i[4*ELEV_WIDTH +: ELEV_WIDTH];
            ew_reg  <= (ew_i == '0) ? SPACING_W'(1) : ew_i;
            ns_reg  <= (ns_i == '0) ? SPACING_W'(1) : ns_i;
        end
    end

    assign abs_a = a_reg[DIFF_W-1] ? DIFF_W'(-a_reg) : DIFF_W'(a_reg);
    assign abs_b = b_reg[DIFF_W-1] ? DIFF_W'(-b_reg) : DIFF_W'(b_reg);

    // Stage 2: cross products with the spacings
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
        if (en) begin
            ok2_reg   <= ok1_reg;
            c2_reg    <= c1_reg;
            apos2_reg <= !a_reg[DIFF_W-1] && (a_reg != '0);
            bneg2_reg <= b_reg[DIFF_W-1];
            flat2_reg <= (a_reg == '0) && (b_reg == '0);
            mx_reg    <= NW'(abs_a) * NW'(ns_reg);
            my_reg    <= NW'(abs_b) * NW'(ew_reg);
            md_reg    <= NW'({32'(ew_reg) * 32'(ns_reg), 3'b000});
        end
    end

    always_comb begin
        max_next = (mx_reg > my_reg) ? mx_reg : my_reg;
        if (md_reg > max_next) begin
            max_next = md_reg;
        end
    end

    // Stage 3: largest magnitude
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nrm_reg[0].vld <= 1'b0;
        end else if (en) begin
            nrm_reg[0].vld <= v2_reg;
        end
        if (en) begin
            nrm_reg[0].a_pos  <= apos2_reg;
            nrm_reg[0].b_neg  <= bneg2_reg;
            nrm_reg[0].flat   <= flat2_reg;
            nrm_reg[0].win_ok <= ok2_reg;
            nrm_reg[0].centre <= c2_reg;
            nrm_reg[0].mx     <= mx_reg;
            nrm_reg[0].my     <= my_reg;
            nrm_reg[0].md     <= md_reg;
            nrm_reg[0].m      <= max_next;
        end
    end

    // Stages 4..9: shift left by 32, 16, 8, 4, 2, 1 until the top bit is set
    for (genvar k = 0; k < NORM_STAGES; k++) begin : g_norm
        localparam int SH = 32 >> k;
        logic do_sh;
        assign do_sh = (nrm_reg[k].m[NW-1 -: SH] == '0);
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                nrm_reg[k+1].vld <= 1'b0;
            end else if (en) begin
                nrm_reg[k+1].vld <= nrm_reg[k].vld;
            end
            if (en) begin
                nrm_reg[k+1].a_pos  <= nrm_reg[k].a_pos;
                nrm_reg[k+1].b_neg  <= nrm_reg[k].b_neg;
                nrm_reg[k+1].flat   <= nrm_reg[k].flat;
                nrm_reg[k+1].win_ok <= nrm_reg[k].win_ok;
                nrm_reg[k+1].centre <= nrm_reg[k].centre;
                nrm_reg[k+1].mx     <= do_sh ? (nrm_reg[k].mx << SH) : nrm_reg[k].mx;
                nrm_reg[k+1].my     <= do_sh ? (nrm_reg[k].my << SH) : nrm_reg[k].my;
                nrm_reg[k+1].md     <= do_sh ? (nrm_reg[k].md << SH) : nrm_reg[k].md;
                nrm_reg[k+1].m      <= do_sh ? (nrm_reg[k].m << SH) : nrm_reg[k].m;
            end
        end
    end

    // Stage 10: fold into the right half plane, seed the aspect angle
    logic               neg_y;
    logic signed [CW-1:0] my_ext;
    assign neg_y  = nrm_reg[NORM_STAGES].a_pos ^ nrm_reg[NORM_STAGES].b_neg;
    assign my_ext = CW'(nrm_reg[NORM_STAGES].my);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_o <= 1'b0;
        end else if (en) begin
            vld_o <= nrm_reg[NORM_STAGES].vld;
        end
        if (en) begin
            x_o           <= CW'(nrm_reg[NORM_STAGES].mx);
            y_o           <= neg_y ? -my_ext : my_ext;
            d_o           <= CW'(nrm_reg[NORM_STAGES].md);
            side_o.win_ok <= nrm_reg[NORM_STAGES].win_ok;
            side_o.flat   <= nrm_reg[NORM_STAGES].flat;
            side_o.centre <= nrm_reg[NORM_STAGES].centre;
            if (nrm_reg[NORM_STAGES].a_pos) begin
                side_o.ang <= nrm_reg[NORM_STAGES].b_neg ? -PI_Q30 : PI_Q30;
            end else begin
                side_o.ang <= '0;
            end
        end
    end

endmodule

// ===== src/hsa_cordic_stage.sv =====
// One registered vectoring rotation step with a sideband that travels along.
module hsa_cordic_stage
    import hsa_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic [ITER_W-1:0]    iter_i,
    input  logic                 vld_i,
    input  logic signed [CW-1:0] x_i,
    input  logic signed [CW-1:0] y_i,
    input  logic signed [ZW-1:0] z_i,
    input  side_t                side_i,
    output logic                 vld_o,
    output logic signed [CW-1:0] x_o,
    output logic signed [CW-1:0] y_o,
    output logic signed [ZW-1:0] z_o,
    output side_t                side_o
);

    logic signed [CW-1:0] dx, dy;
    logic signed [ZW-1:0] t;
    logic                 pos;

    assign dx  = y_i >>> iter_i;
    assign dy  = x_i >>> iter_i;
    assign t   = ZW'(atan_q30(iter_i));
    assign pos = !y_i[CW-1] && (y_i != '0);

    // Rotate toward the x axis
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_o <= 1'b0;
        end else if (en) begin
            vld_o <= vld_i;
        end
        if (en) begin
            x_o    <= pos ? (x_i + dx) : (x_i - dx);
            y_o    <= pos ? (y_i - dy) : (y_i + dy);
            z_o    <= pos ? (z_i + t) : (z_i - t);
            side_o <= side_i;
        end
    end

endmodule

// ===== src/horn_slope_aspect_3x3_unit.sv =====
// Top level of the Horn 3x3 slope and aspect unit.
// Takes one 3x3 elevation window per clock unless the output is stalled and returns one
// result per window, in order, through 10 front-end stages (differences, spacing products,
// six-step normalization), 30 rotation stages that resolve the aspect and the spacing
// gain in parallel, 30 rotation stages for the slope, and the output register. The
// pipeline holds as a whole while the output is stalled; s_tready is low only then.
// Spacing writes take effect for windows accepted after the write.
module horn_slope_aspect_3x3_unit
    import hsa_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // elev_nw, elev_n, elev_ne, elev_w, elev_c, elev_e, elev_sw, elev_s, elev_se
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // window_valid
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // centre_elevation, slope, aspect
    output logic [OUT_DATA_W-1:0] m_tdata,
    // ok
    output logic                  m_tuser,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [SPACING_W-1:0]  cfg_data
);

    logic                 en;
    logic [SPACING_W-1:0] ew_reg, ns_reg;

    logic                 va   [0:ITERS];
    logic signed [CW-1:0] xa   [0:ITERS];
    logic signed [CW-1:0] ya   [0:ITERS];
    logic signed [ZW-1:0] za   [0:ITERS];
    side_t                sa   [0:ITERS];
    logic signed [CW-1:0] xd   [0:ITERS];
    logic signed [CW-1:0] yd   [0:ITERS];

    logic                 vs   [0:ITERS];
    logic signed [CW-1:0] xs   [0:ITERS];
    logic signed [CW-1:0] ys   [0:ITERS];
    logic signed [ZW-1:0] zs   [0:ITERS];
    side_t                ss   [0:ITERS];

    logic                 m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic                 m_tuser_reg;

    // Advance the whole pipeline unless a result waits on the output
    assign en        = !m_tvalid_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    // Spacing registers; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ew_reg <= SPACING_W'(16);
            ns_reg <= SPACING_W'(16);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_EW_SPACING: ew_reg <= cfg_data;
                CFG_NS_SPACING: ns_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    hsa_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .vld_i    (s_tvalid && s_tready),
        .elev_i   (s_tdata),
        .win_ok_i (s_tuser),
        .ew_i     (ew_reg),
        .ns_i     (ns_reg),
        .vld_o    (va[0]),
        .x_o      (xa[0]),
        .y_o      (ya[0]),
        .d_o      (xd[0]),
        .side_o   (sa[0])
    );

    assign za[0] = sa[0].ang;
    assign yd[0] = '0;

    // Aspect rotation and spacing gain run side by side
    for (genvar i = 0; i < ITERS; i++) begin : g_asp
        hsa_cordic_stage u_asp (
            .aclk (aclk), .aresetn (aresetn), .en (en), .iter_i (ITER_W'(i)),
            .vld_i (va[i]), .x_i (xa[i]), .y_i (ya[i]), .z_i (za[i]), .side_i (sa[i]),
            .vld_o (va[i+1]), .x_o (xa[i+1]), .y_o (ya[i+1]), .z_o (za[i+1]),
            .side_o (sa[i+1])
        );
        hsa_cordic_stage u_gain (
            .aclk (aclk), .aresetn (aresetn), .en (en), .iter_i (ITER_W'(i)),
            .vld_i (va[i]), .x_i (xd[i]), .y_i (yd[i]), .z_i ('0), .side_i (sa[i]),
            .vld_o (), .x_o (xd[i+1]), .y_o (yd[i+1]), .z_o (), .side_o ()
        );
    end

    // Slope: angle of (scaled spacing term, scaled gradient magnitude)
    always_comb begin
        vs[0]        = va[ITERS];
        xs[0]        = xd[ITERS];
        ys[0]        = xa[ITERS];
        zs[0]        = '0;
        ss[0]        = sa[ITERS];
        ss[0].ang    = za[ITERS];
    end

    for (genvar i = 0; i < ITERS; i++) begin : g_slp
        hsa_cordic_stage u_slp (
            .aclk (aclk), .aresetn (aresetn), .en (en), .iter_i (ITER_W'(i)),
            .vld_i (vs[i]), .x_i (xs[i]), .y_i (ys[i]), .z_i (zs[i]), .side_i (ss[i]),
            .vld_o (vs[i+1]), .x_o (xs[i+1]), .y_o (ys[i+1]), .z_o (zs[i+1]),
            .side_o (ss[i+1])
        );
    end

    // Round half up to the output angle scale
    localparam int RSH = 30 - ANGLE_FRAC_BITS;
    logic signed [ZW-1:0] slp_r, asp_r, asp_src, slp_src;
    side_t                fin;

    always_comb begin
        fin     = ss[ITERS];
        slp_src = fin.flat ? '0 : zs[ITERS];
        asp_src = fin.flat ? PI_Q30 : fin.ang;
        slp_r   = (slp_src + (ZW'(1) <<< (RSH - 1))) >>> RSH;
        asp_r   = (asp_src + (ZW'(1) <<< (RSH - 1))) >>> RSH;
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= vs[ITERS];
        end
        if (en) begin
            m_tuser_reg <= fin.win_ok;
            if (fin.win_ok) begin
                m_tdata_reg <= {asp_r[ASPECT_W-1:0], slp_r[SLOPE_W-1:0], fin.centre};
            end else begin
                m_tdata_reg <= '0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");
    a_stall_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");
    a_not_ok_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("incomplete window gave nonzero result");
    a_cfg_open: assert property (@(posedge aclk) cfg_ready)
        else $error("configuration channel blocked");
`endif

endmodule
